// ===== sv/cgmd_pkg.sv =====
package cgmd_pkg;

    // channel and configuration widths
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 80;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 2;
    localparam int RATE_W     = 32;

    // control register layout
    localparam int DIV_WIDTH = 5;
    localparam int DIV_POS   = 0;
    localparam int MUX_POS   = 24;
    localparam int GATE_POS  = 31;

    // largest divider, and the field value that encodes it
    localparam logic [RATE_W-1:0]    DIV_MAX       = RATE_W'(1) << DIV_WIDTH;
    localparam logic [DIV_WIDTH-1:0] DIV_FIELD_MAX = '1;

    // operation codes
    localparam logic [2:0] FUNC_ENABLE  = 3'd0;
    localparam logic [2:0] FUNC_DISABLE = 3'd1;
    localparam logic [2:0] FUNC_SELECT  = 3'd2;
    localparam logic [2:0] FUNC_SETRATE = 3'd3;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_GATE_PRESENT = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SEL_WIDTH    = 1'b1;

    // mux width that keeps the divider always in use, and the divided parent
    localparam logic [1:0] WIDE_MUX   = 2'd3;
    localparam logic [2:0] DIV_PARENT = 3'd1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load_in;
        logic apply_op;
        logic q_start;
        logic set_div;
        logic r_start;
        logic load_out;
    } cgmd_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic need_q;
        logic div_active;
        logic div_done;
        logic out_free;
    } cgmd_status_t;

endpackage

// ===== sv/cgmd_div.sv =====
module cgmd_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [cgmd_pkg::RATE_W-1:0] dividend,
    input  logic [cgmd_pkg::RATE_W-1:0] divisor,
    output logic                       done,
    output logic [cgmd_pkg::RATE_W-1:0] quotient
);
    import cgmd_pkg::*;

    localparam int CNT_W = $clog2(RATE_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [RATE_W-1:0] rem_reg;
    logic [RATE_W-1:0] quo_reg;
    logic [RATE_W-1:0] dsr_reg;

    logic [RATE_W:0]   rem_shift;
    logic [RATE_W:0]   diff;
    logic              ge;

    // one restoring step: shift in the next dividend bit, try the subtract
    always_comb begin
        rem_shift = {rem_reg, quo_reg[RATE_W-1]};
        diff      = rem_shift - {1'b0, dsr_reg};
        ge        = rem_shift >= {1'b0, dsr_reg};
    end

    // control: busy for one step per quotient bit, done pulses once after
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(RATE_W - 1);
        end else if (busy_reg) begin
            cnt_reg  <= cnt_reg - CNT_W'(1);
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    // quotient shares the dividend register, bits enter at the bottom
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[RATE_W-1:0] : rem_shift[RATE_W-1:0];
            quo_reg <= {quo_reg[RATE_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== sv/cgmd_datapath.sv =====
module cgmd_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  cgmd_pkg::cgmd_cmd_t            cmd,
    output cgmd_pkg::cgmd_status_t         status,
    input  logic                           cfg_we,
    input  logic [cgmd_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [cgmd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic [cgmd_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           m_tready,
    output logic                           m_tvalid,
    output logic [cgmd_pkg::M_TDATA_W-1:0]  m_tdata
);
    import cgmd_pkg::*;

    // configuration and clock module state
    logic                 gate_present_reg;
    logic [1:0]           sel_width_reg;
    logic                 gate_en_reg;
    logic [2:0]           psel_reg;
    logic [DIV_WIDTH-1:0] dm1_reg;

    // latched input word
    logic [2:0]        func_reg;
    logic [2:0]        pidx_reg;
    logic [RATE_W-1:0] target_reg;
    logic [RATE_W-1:0] prate_reg;

    // output register
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] out_reg;

    logic [2:0]           sel_mask;
    logic [2:0]           psel_m;
    logic                 div_active;
    logic                 en;
    logic [7:0]           dfield;
    logic [RATE_W-1:0]    word;
    logic [RATE_W-1:0]    orate;
    logic [DIV_WIDTH-1:0] dm1_from_q;
    logic                 div_start;
    logic [RATE_W-1:0]    div_divisor;
    logic                 div_done;
    logic [RATE_W-1:0]    div_quot;

    // select mask from the mux width
    always_comb begin
        case (sel_width_reg)
            2'd0:    sel_mask = 3'b000;
            2'd1:    sel_mask = 3'b001;
            2'd2:    sel_mask = 3'b011;
            default: sel_mask = 3'b111;
        endcase
    end

    // status view of the state
    always_comb begin
        psel_m     = psel_reg & sel_mask;
        div_active = (sel_width_reg == WIDE_MUX) || (psel_m == DIV_PARENT);
        en         = gate_present_reg ? gate_en_reg : 1'b1;
        dfield     = 8'(dm1_reg);
        word       = (RATE_W'(psel_m) << MUX_POS)
                   | (RATE_W'(dfield) << DIV_POS)
                   | (RATE_W'(gate_present_reg & gate_en_reg) << GATE_POS);
        orate      = div_active ? div_quot : prate_reg;
    end

    // clamp the quotient to 1 .. DIV_MAX and keep divider minus one
    always_comb begin
        if (div_quot > DIV_MAX) begin
            dm1_from_q = DIV_FIELD_MAX;
        end else if (div_quot == '0) begin
            dm1_from_q = '0;
        end else begin
            dm1_from_q = DIV_WIDTH'(div_quot - RATE_W'(1));
        end
    end

    // shared divider: parent / target, then parent / divider
    assign div_start   = cmd.q_start | cmd.r_start;
    assign div_divisor = cmd.r_start ? (RATE_W'(dm1_reg) + RATE_W'(1)) : target_reg;

    cgmd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prate_reg),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // configuration writes and operations on the control register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gate_present_reg <= 1'b1;
            sel_width_reg    <= 2'd1;
            gate_en_reg      <= 1'b0;
            psel_reg         <= '0;
            dm1_reg          <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_GATE_PRESENT: gate_present_reg <= cfg_wdata[0];
                    CFG_SEL_WIDTH:    sel_width_reg    <= cfg_wdata[1:0];
                    default:          ;
                endcase
            end
            if (cmd.apply_op) begin
                case (func_reg)
                    FUNC_ENABLE:  if (gate_present_reg) gate_en_reg <= 1'b1;
                    FUNC_DISABLE: if (gate_present_reg) gate_en_reg <= 1'b0;
                    FUNC_SELECT:  psel_reg <= pidx_reg & sel_mask;
                    FUNC_SETRATE: if (div_active && target_reg == '0) dm1_reg <= '0;
                    default:      ;
                endcase
            end
            if (cmd.set_div) begin
                dm1_reg <= dm1_from_q;
            end
        end
    end

    // input word capture
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            func_reg   <= s_tdata[2:0];
            pidx_reg   <= s_tdata[5:3];
            target_reg <= s_tdata[37:6];
            prate_reg  <= s_tdata[69:38];
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_reg <= {4'b0, word, orate, dfield, psel_m, en};
        end
    end

    assign status.need_q     = (func_reg == FUNC_SETRATE) && div_active && (target_reg != '0);
    assign status.div_active = div_active;
    assign status.div_done   = div_done;
    assign status.out_free   = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

endmodule

// ===== sv/cgmd_ctrl.sv =====
module cgmd_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  cgmd_pkg::cgmd_status_t status,
    output cgmd_pkg::cgmd_cmd_t    cmd
);
    import cgmd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OP,
        ST_Q_WAIT,
        ST_R_CHECK,
        ST_R_WAIT,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
                if (s_tvalid) state_next = ST_OP;
            end
            ST_OP: begin
                cmd.apply_op = 1'b1;
                cmd.q_start  = status.need_q;
                state_next   = status.need_q ? ST_Q_WAIT : ST_R_CHECK;
            end
            ST_Q_WAIT: begin
                if (status.div_done) begin
                    cmd.set_div = 1'b1;
                    state_next  = ST_R_CHECK;
                end
            end
            ST_R_CHECK: begin
                cmd.r_start = status.div_active;
                state_next  = status.div_active ? ST_R_WAIT : ST_FINISH;
            end
            ST_R_WAIT: begin
                if (status.div_done) state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/clock_gate_mux_divider_top.sv =====
// channel  | direction | ports                       | content
// s_       | in        | s_tvalid s_tready s_tdata   | one operation word
// m_       | out       | m_tvalid m_tready m_tdata   | one status word per operation
// cfg_     | in        | cfg_we cfg_addr cfg_wdata   | gate_present, sel_width
//
// with the divider idle an accepted word passes the operation, divider check and
// finish states before its status word is registered, and no new word is taken
// until the controller is back in idle. set rate with a nonzero target on an
// active divider takes two passes through the shared bit-serial divider, any
// other word on an active divider one.
// aresetn is synchronous: gate off, parent 0, divider 1, gate present, mux width 1.
// a new word is taken while the previous status word waits on m_tready;
// a finished status waits in the controller until the output register frees.
module clock_gate_mux_divider_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    // func[2:0], parent_pick[5:3], target_rate[37:6], src_rate[69:38]
    input  logic [cgmd_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // enabled[0], parent_select[3:1], divider_field[11:4],
    // output_rate[43:12], control_word[75:44]
    output logic [cgmd_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            cfg_we,
    input  logic [cgmd_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [cgmd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import cgmd_pkg::*;

    cgmd_cmd_t    cmd;
    cgmd_status_t status;

    cgmd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cgmd_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== sv/cgmd_checker.sv =====
module cgmd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata
);

    // a stalled status word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("status word changed while stalled");

    // one word in flight: no accept in the cycle after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken twice in a row");

    // control word carries the same parent and divider fields
    a_word_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[74:68] == {4'b0, m_tdata[3:1]}
                     && m_tdata[51:44] == m_tdata[11:4])
        else $error("control word fields disagree");

    // gate bit in the control word implies enabled
    a_gate_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[75] |-> m_tdata[0])
        else $error("gate bit set while disabled");

    // no status word straight after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("status word valid after reset");

endmodule

bind clock_gate_mux_divider_top cgmd_checker u_cgmd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== dv/tb_clock_gate_mux_divider_top.sv =====
`timescale 1ns / 1ps

module tb_clock_gate_mux_divider_top;
    import cgmd_pkg::*;

    // codes the package leaves out: query and the unused operation range
    localparam logic [2:0] FUNC_QUERY  = 3'd4;
    localparam logic [2:0] FUNC_BAD_LO = 3'd5;
    localparam logic [2:0] FUNC_BAD_HI = 3'd7;

    localparam int N_PHASES    = 6;
    localparam int PHASE_WORDS = 64;
    localparam int TAIL_CYCLES = 100;

    // one operation word, as the sender sees it
    typedef struct packed {
        logic [2:0]        func;
        logic [2:0]        parent_pick;
        logic [RATE_W-1:0] target_rate;
        logic [RATE_W-1:0] src_rate;
    } op_word_t;

    // one status word, enabled in the top bit
    typedef struct packed {
        logic              enabled;
        logic [2:0]        parent_select;
        logic [7:0]        divider_field;
        logic [RATE_W-1:0] output_rate;
        logic [31:0]       control_word;
    } status_t;

    typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

    // directed stimulus row: an operation word or a new controller setting
    typedef struct {
        row_kind_t  kind;
        op_word_t   op;
        logic       known;
        status_t    want;
        logic       gate_present;
        logic [1:0] sel_width;
    } dir_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // predicted controller settings and clock module state
    logic       pr_gate_present;
    logic [1:0] pr_sel_width;
    logic       pr_gate_en;
    logic [2:0] pr_parent;
    logic [7:0] pr_div_m1;

    status_t  status_q [$];
    dir_row_t dir_rows [$];

    int src_idle_pct;
    int snk_idle_pct;
    int n_sent;
    int n_checked;
    int n_settings;
    int n_errors;

    logic       gp_plan [N_PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    logic [1:0] mw_plan [N_PHASES] = '{2'd1, 2'd3, 2'd2, 2'd0, 2'd3, 2'd1};

    clock_gate_mux_divider_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // divider in use: widest mux, or parent 1 seen through the mask
    function automatic logic divider_on(input logic [2:0] msk);
        return pr_sel_width == WIDE_MUX || (pr_parent & msk) == DIV_PARENT;
    endfunction

    // apply one operation to the predicted state and return the status after it
    function automatic status_t next_status(input op_word_t w);
        logic [2:0]        msk;
        logic [RATE_W-1:0] quot;
        status_t           st;
        msk = 3'((8'd1 << pr_sel_width) - 8'd1);
        case (w.func)
            FUNC_ENABLE: begin
                if (pr_gate_present) pr_gate_en = 1'b1;
            end
            FUNC_DISABLE: begin
                if (pr_gate_present) pr_gate_en = 1'b0;
            end
            FUNC_SELECT: begin
                pr_parent = w.parent_pick & msk;
            end
            FUNC_SETRATE: begin
                if (divider_on(msk)) begin
                    // zero target means divide by one; clamp to 1..DIV_MAX
                    if (w.target_rate == '0)
                        quot = RATE_W'(1);
                    else
                        quot = w.src_rate / w.target_rate;
                    if (quot < RATE_W'(1)) quot = RATE_W'(1);
                    if (quot > DIV_MAX) quot = DIV_MAX;
                    pr_div_m1 = 8'(quot - RATE_W'(1)) & 8'(DIV_FIELD_MAX);
                end
            end
            default: ;
        endcase
        st.enabled       = pr_gate_present ? pr_gate_en : 1'b1;
        st.parent_select = pr_parent & msk;
        st.divider_field = pr_div_m1 & 8'(DIV_FIELD_MAX);
        if (divider_on(msk))
            st.output_rate = w.src_rate / (RATE_W'(st.divider_field) + RATE_W'(1));
        else
            st.output_rate = w.src_rate;
        st.control_word = (32'(st.parent_select) << MUX_POS)
                        | (32'(st.divider_field) << DIV_POS);
        if (pr_gate_present && st.enabled) st.control_word[GATE_POS] = 1'b1;
        return st;
    endfunction

    // random operation, biased towards parent 1 and divider updates
    function automatic op_word_t random_word();
        op_word_t    w;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 12)
            w.func = FUNC_ENABLE;
        else if (pick < 22)
            w.func = FUNC_DISABLE;
        else if (pick < 40)
            w.func = FUNC_SELECT;
        else if (pick < 76)
            w.func = FUNC_SETRATE;
        else if (pick < 92)
            w.func = FUNC_QUERY;
        else
            w.func = 3'($urandom_range(FUNC_BAD_LO, FUNC_BAD_HI));
        if (w.func == FUNC_SELECT && $urandom_range(0, 1) == 0)
            w.parent_pick = DIV_PARENT;
        else
            w.parent_pick = 3'($urandom_range(0, 7));
        case ($urandom_range(0, 3))
            0:       w.src_rate = $urandom_range(0, 1000);
            1:       w.src_rate = 32'hFFFF_FFFF - $urandom_range(0, 15);
            default: w.src_rate = $urandom;
        endcase
        case ($urandom_range(0, 4))
            0:       w.target_rate = '0;
            1:       w.target_rate = $urandom_range(1, 64);
            2:       w.target_rate = w.src_rate / $urandom_range(1, 40);
            3:       w.target_rate = 32'hFFFF_FFFF;
            default: w.target_rate = $urandom;
        endcase
        return w;
    endfunction

    task automatic add_word(input logic [2:0] f, input logic [2:0] p,
                            input logic [31:0] t, input logic [31:0] r);
        dir_row_t row;
        row.kind  = ROW_WORD;
        row.op    = {f, p, t, r};
        row.known = 1'b0;
        row.want  = '0;
        dir_rows.push_back(row);
    endtask

    task automatic add_known(input logic [2:0] f, input logic [2:0] p,
                             input logic [31:0] t, input logic [31:0] r,
                             input status_t want);
        dir_row_t row;
        row.kind  = ROW_WORD;
        row.op    = {f, p, t, r};
        row.known = 1'b1;
        row.want  = want;
        dir_rows.push_back(row);
    endtask

    task automatic add_cfg(input logic gp, input logic [1:0] mw);
        dir_row_t row;
        row.kind         = ROW_CFG;
        row.op           = '0;
        row.known        = 1'b0;
        row.want         = '0;
        row.gate_present = gp;
        row.sel_width    = mw;
        dir_rows.push_back(row);
    endtask

    // offer one word, with an optional idle gap first; predict on acceptance
    task automatic send_word(input op_word_t w, input logic known, input status_t want);
        status_t st;
        if ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        s_tdata  <= S_TDATA_W'({w.src_rate, w.target_rate, w.parent_pick, w.func});
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        st = next_status(w);
        status_q.push_back(known ? want : st);
        n_sent++;
    endtask

    // new controller setting, only once every status word is back
    task automatic write_cfg(input logic gp, input logic [1:0] mw);
        s_tvalid <= 1'b0;
        while (status_q.size() != 0) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_GATE_PRESENT;
        cfg_wdata <= CFG_DATA_W'(gp);
        @(posedge aclk);
        cfg_addr  <= CFG_SEL_WIDTH;
        cfg_wdata <= mw;
        @(posedge aclk);
        cfg_we <= 1'b0;
        pr_gate_present = gp;
        pr_sel_width    = mw;
        n_settings++;
    endtask

    // compare one status word with the oldest prediction
    task automatic check_word(input logic [M_TDATA_W-1:0] d);
        status_t want;
        status_t got;
        got.enabled       = d[0];
        got.parent_select = d[3:1];
        got.divider_field = d[11:4];
        got.output_rate   = d[43:12];
        got.control_word  = d[75:44];
        if (status_q.size() == 0) begin
            n_errors++;
            $error("status word with nothing outstanding: %h", d);
        end else begin
            want = status_q.pop_front();
            n_checked++;
            if (got.enabled !== want.enabled) begin
                n_errors++;
                $error("enabled: expected %0d, got %0d", want.enabled, got.enabled);
            end
            if (got.parent_select !== want.parent_select) begin
                n_errors++;
                $error("parent_select: expected %0d, got %0d",
                       want.parent_select, got.parent_select);
            end
            if (got.divider_field !== want.divider_field) begin
                n_errors++;
                $error("divider_field: expected %0d, got %0d",
                       want.divider_field, got.divider_field);
            end
            if (got.output_rate !== want.output_rate) begin
                n_errors++;
                $error("output_rate: expected %0d, got %0d",
                       want.output_rate, got.output_rate);
            end
            if (got.control_word !== want.control_word) begin
                n_errors++;
                $error("control_word: expected %h, got %h",
                       want.control_word, got.control_word);
            end
        end
    endtask

    // result side: check on handshake, then pick next ready
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) check_word(m_tdata);
        m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    initial begin
        int       ph;
        int       i;
        op_word_t w;

        pr_gate_present = 1'b1;
        pr_sel_width    = 2'd1;
        pr_gate_en      = 1'b0;
        pr_parent       = 3'd0;
        pr_div_m1       = 8'd0;
        src_idle_pct    = 35;
        snk_idle_pct    = 64;
        n_sent          = 0;
        n_checked       = 0;
        n_settings      = 0;
        n_errors        = 0;

        // state straight after reset, then the extremes of each operation
        add_known(FUNC_QUERY, 3'd0, 32'd0, 32'd1000, {1'b0, 3'd0, 8'd0, 32'd1000, 32'h0});
        add_known(FUNC_ENABLE, 3'd0, 32'd0, 32'd0,
                  {1'b1, 3'd0, 8'd0, 32'd0, 32'h8000_0000});
        // divider idle on parent 0: set rate has no effect
        add_known(FUNC_SETRATE, 3'd0, 32'd1, 32'd100,
                  {1'b1, 3'd0, 8'd0, 32'd100, 32'h8000_0000});
        // parent 7 masked down to 1 by the one-bit mux
        add_known(FUNC_SELECT, 3'd7, 32'd0, 32'hFFFF_FFFF,
                  {1'b1, 3'd1, 8'd0, 32'hFFFF_FFFF, 32'h8100_0000});
        // quotient far above the maximum clamps to the top field
        add_known(FUNC_SETRATE, 3'd0, 32'd1, 32'hFFFF_FFFF,
                  {1'b1, 3'd1, 8'd31, 32'h07FF_FFFF, 32'h8100_001F});
        add_word(FUNC_SETRATE, 3'd0, 32'd0, 32'd5000);
        add_word(FUNC_SETRATE, 3'd5, 32'hFFFF_FFFF, 32'd1);
        add_word(FUNC_SETRATE, 3'd0, 32'd3, 32'd10);
        add_word(FUNC_QUERY, 3'd0, 32'd0, 32'h1234_5678);
        add_word(FUNC_DISABLE, 3'd0, 32'd0, 32'd777);
        add_word(FUNC_BAD_LO, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_word(FUNC_BAD_HI, 3'd2, 32'd5, 32'd99);
        // no gate: always enabled, gate bit never set
        add_cfg(1'b0, 2'd1);
        add_word(FUNC_ENABLE, 3'd0, 32'd0, 32'd64);
        add_word(FUNC_DISABLE, 3'd0, 32'd0, 32'd64);
        // widest mux keeps the divider in use on any parent
        add_cfg(1'b0, 2'd3);
        add_word(FUNC_SELECT, 3'd6, 32'd0, 32'd100);
        add_word(FUNC_SETRATE, 3'd0, 32'd7, 32'd100);
        // narrower mux reads the stored parent through the new mask
        add_cfg(1'b1, 2'd2);
        add_word(FUNC_QUERY, 3'd0, 32'd0, 32'd4096);
        // zero-width mux: parent always 0, divider unused
        add_cfg(1'b1, 2'd0);
        add_word(FUNC_QUERY, 3'd0, 32'd0, 32'd4096);
        add_word(FUNC_SELECT, 3'd5, 32'd0, 32'd300);
        add_word(FUNC_SETRATE, 3'd0, 32'd2, 32'd1000);
        add_cfg(1'b1, 2'd1);
        add_word(FUNC_QUERY, 3'd0, 32'd0, 32'd123);

        aresetn <= 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        for (i = 0; i < dir_rows.size(); i++) begin
            if (dir_rows[i].kind == ROW_CFG)
                write_cfg(dir_rows[i].gate_present, dir_rows[i].sel_width);
            else
                send_word(dir_rows[i].op, dir_rows[i].known, dir_rows[i].want);
        end

        // random phases, each under its own controller setting
        for (ph = 0; ph < N_PHASES; ph++) begin
            if (ph == 2) begin
                src_idle_pct = 64;
                snk_idle_pct = 35;
            end else if (ph == 4) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            write_cfg(gp_plan[ph], mw_plan[ph]);
            repeat (PHASE_WORDS) begin
                w = random_word();
                send_word(w, 1'b0, '0);
            end
        end

        // drain, then allow for anything stray
        s_tvalid <= 1'b0;
        while (status_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("sent %0d operation words over %0d controller settings",
                 n_sent, n_settings);
        $display("checked %0d status words, %0d field errors", n_checked, n_errors);
        if (n_errors == 0 && status_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("run timed out with %0d status words outstanding", status_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
